// ===== rtl/core/fvoc_pkg.sv =====
// Shared types, constants and register indexes of the fractional open circuit voltage controller.
package fvoc_pkg;

  // Sample and timer widths.
  localparam int ADC_BITS   = 12;
  localparam int TIMER_BITS = 16;

  // Field widths fixed by the interface.
  localparam int CYCLE_W   = 6;
  localparam int STRETCH_W = 4;
  localparam int DUTY_W    = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Duty curve in Q16: gain round(80.0064 * 2^16), offset round(27.78 * 2^16).
  localparam int GAIN_W   = 23;
  localparam int OFFSET_W = 21;
  localparam logic [GAIN_W-1:0]   GAIN_Q16   = 23'd5243299;
  localparam logic [OFFSET_W-1:0] OFFSET_Q16 = 21'd1820590;
  localparam int PROD_W   = ADC_BITS + GAIN_W;
  localparam int DUTY_SHIFT = 16 + ADC_BITS;
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  // Event kinds.
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_TIMER = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_FACTOR = 2'd3;

  // Reset values.
  localparam logic [ADC_BITS-1:0]   VBAT_LIMIT_RST     = 12'd3823;
  localparam logic [CYCLE_W-1:0]    CYCLE_LIMIT_RST    = 6'd20;
  localparam logic [TIMER_BITS-1:0] BASE_PERIOD_RST    = 16'd64000;
  localparam logic [STRETCH_W-1:0]  STRETCH_FACTOR_RST = 4'd6;

  typedef struct packed {
    logic [ADC_BITS-1:0]   vbat_limit;
    logic [CYCLE_W-1:0]    cycle_limit;
    logic [TIMER_BITS-1:0] base_period;
    logic [STRETCH_W-1:0]  stretch_factor;
  } cfg_t;

  typedef struct packed {
    logic                  shutdown_level;
    logic                  falling_edge_select;
    logic                  edge_enable;
    logic [CYCLE_W-1:0]    cycle_count;
    logic [TIMER_BITS-1:0] period_reg;
    logic [DUTY_W-1:0]     duty_reg;
  } ctl_state_t;

endpackage

// ===== rtl/core/fvoc_duty.sv =====
// Fixed point duty curve: duty = trunc(80.0064 * voc / 2^ADC_BITS - 27.78), clamped.
module fvoc_duty (
  input  logic [fvoc_pkg::ADC_BITS-1:0] voc,
  output logic [fvoc_pkg::DUTY_W-1:0]   duty
);

  localparam int SCALED_W = fvoc_pkg::PROD_W - fvoc_pkg::DUTY_SHIFT;

  logic [fvoc_pkg::PROD_W-1:0] pos;
  logic [fvoc_pkg::PROD_W-1:0] neg;
  logic [fvoc_pkg::PROD_W-1:0] diff;
  logic [SCALED_W-1:0]         scaled;

  // Gain product and offset scaled up to the same binary point.
  assign pos = fvoc_pkg::PROD_W'(voc) * fvoc_pkg::PROD_W'(fvoc_pkg::GAIN_Q16);
  assign neg = fvoc_pkg::PROD_W'(fvoc_pkg::OFFSET_Q16) << fvoc_pkg::ADC_BITS;
  assign diff = pos - neg;
  assign scaled = diff[fvoc_pkg::PROD_W-1:fvoc_pkg::DUTY_SHIFT];

  // Negative results clamp to zero, large ones saturate.
  always_comb begin
    if (pos < neg) begin
      duty = '0;
    end else if (scaled > SCALED_W'(fvoc_pkg::DUTY_MAX)) begin
      duty = fvoc_pkg::DUTY_MAX;
    end else begin
      duty = scaled[fvoc_pkg::DUTY_W-1:0];
    end
  end

endmodule

// ===== rtl/core/fvoc_core.sv =====
// Event update: next controller state and timer clear flag for one event.
module fvoc_core (
  input  fvoc_pkg::cfg_t                  cfg,
  input  fvoc_pkg::ctl_state_t            state,
  input  logic                            cmd,
  input  logic [fvoc_pkg::TIMER_BITS-1:0] timer_count,
  input  logic [fvoc_pkg::ADC_BITS-1:0]   vbat_sample,
  input  logic [fvoc_pkg::ADC_BITS-1:0]   voc_sample,
  output fvoc_pkg::ctl_state_t            state_next,
  output logic                            tclear
);

  localparam int STRETCH_PROD_W = fvoc_pkg::STRETCH_W + fvoc_pkg::TIMER_BITS;

  logic [fvoc_pkg::DUTY_W-1:0]  duty_new;
  logic [fvoc_pkg::CYCLE_W:0]   count_inc;
  logic [STRETCH_PROD_W-1:0]    stretched;

  fvoc_duty u_duty (
    .voc  (voc_sample),
    .duty (duty_new)
  );

  // Count grows one bit so that a wrap past the top always exceeds the limit.
  assign count_inc = {1'b0, state.cycle_count} + 1'b1;
  assign stretched = STRETCH_PROD_W'(cfg.stretch_factor) * STRETCH_PROD_W'(timer_count);

  always_comb begin
    state_next = state;
    tclear     = 1'b0;
    unique case (cmd)
      fvoc_pkg::CMD_EDGE: begin
        // Edges are ignored while the comparator is disabled.
        if (state.edge_enable) begin
          if (state.falling_edge_select) begin
            state_next.shutdown_level      = 1'b1;
            state_next.falling_edge_select = 1'b0;
            tclear                         = 1'b1;
          end else begin
            state_next.falling_edge_select = 1'b1;
            if (count_inc > {1'b0, cfg.cycle_limit}) begin
              // Enough charges: stop edges and stretch the period for a measurement.
              state_next.cycle_count = '0;
              state_next.edge_enable = 1'b0;
              state_next.period_reg  = stretched[fvoc_pkg::TIMER_BITS-1:0];
            end else begin
              state_next.cycle_count    = count_inc[fvoc_pkg::CYCLE_W-1:0];
              state_next.shutdown_level = 1'b0;
            end
          end
        end
      end
      fvoc_pkg::CMD_TIMER: begin
        state_next.period_reg = cfg.base_period;
        if (!state.shutdown_level) begin
          state_next.falling_edge_select = 1'b0;
          state_next.shutdown_level      = 1'b1;
        end else if (vbat_sample >= cfg.vbat_limit) begin
          // Battery full: stop charging.
          state_next.edge_enable = 1'b0;
        end else begin
          state_next.duty_reg            = duty_new;
          state_next.shutdown_level      = 1'b0;
          state_next.falling_edge_select = 1'b1;
          state_next.edge_enable         = 1'b1;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== rtl/core/fractional_voc_mppt_controller.sv =====
// Fractional open circuit voltage charge controller: config registers, state and result register.
// A result is registered and appears in the cycle after its event beat is accepted.
// Throughput: one event per cycle unless stalled; single-pass update and one output register set the pace.
// A new event is taken while the output register is empty or being drained in the same cycle.
// Reset (rst, synchronous) restores the config and state registers to their defaults and empties the output.
module fractional_voc_mppt_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fvoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fvoc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [fvoc_pkg::TIMER_BITS-1:0]     timer_count,
  input  logic [fvoc_pkg::ADC_BITS-1:0]       vbat_sample,
  input  logic [fvoc_pkg::ADC_BITS-1:0]       voc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                shutdown,
  output logic [fvoc_pkg::DUTY_W-1:0]         duty,
  output logic [fvoc_pkg::TIMER_BITS-1:0]     timer_period,
  output logic                                comparator_enabled,
  output logic                                timer_clear
);

  fvoc_pkg::cfg_t       cfg;
  fvoc_pkg::ctl_state_t state;
  fvoc_pkg::ctl_state_t state_next;
  logic                 tclear;
  logic                 in_fire;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vbat_limit     <= fvoc_pkg::VBAT_LIMIT_RST;
      cfg.cycle_limit    <= fvoc_pkg::CYCLE_LIMIT_RST;
      cfg.base_period    <= fvoc_pkg::BASE_PERIOD_RST;
      cfg.stretch_factor <= fvoc_pkg::STRETCH_FACTOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fvoc_pkg::REG_VBAT_LIMIT:     cfg.vbat_limit     <= cfg_data[fvoc_pkg::ADC_BITS-1:0];
        fvoc_pkg::REG_CYCLE_LIMIT:    cfg.cycle_limit    <= cfg_data[fvoc_pkg::CYCLE_W-1:0];
        fvoc_pkg::REG_BASE_PERIOD:    cfg.base_period    <= cfg_data[fvoc_pkg::TIMER_BITS-1:0];
        fvoc_pkg::REG_STRETCH_FACTOR: cfg.stretch_factor <= cfg_data[fvoc_pkg::STRETCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fvoc_core u_core (
    .cfg         (cfg),
    .state       (state),
    .cmd         (cmd),
    .timer_count (timer_count),
    .vbat_sample (vbat_sample),
    .voc_sample  (voc_sample),
    .state_next  (state_next),
    .tclear      (tclear)
  );

  // Controller state advances on every accepted event beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.shutdown_level      <= 1'b0;
      state.falling_edge_select <= 1'b0;
      state.edge_enable         <= 1'b1;
      state.cycle_count         <= fvoc_pkg::CYCLE_W'(1);
      state.period_reg          <= fvoc_pkg::BASE_PERIOD_RST;
      state.duty_reg            <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with the state after the event.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      shutdown           <= state_next.shutdown_level;
      duty               <= state_next.duty_reg;
      timer_period       <= state_next.period_reg;
      comparator_enabled <= state_next.edge_enable;
      timer_clear        <= tclear;
    end
  end

endmodule

// ===== tb/fvoc_result_checker.sv =====
// Result checker for the fractional open circuit voltage charge controller.
`timescale 1ns / 1ps
module fvoc_result_checker
  import fvoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  cmd,
  input  logic [TIMER_BITS-1:0] timer_count,
  input  logic [ADC_BITS-1:0]   vbat_sample,
  input  logic [ADC_BITS-1:0]   voc_sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  shutdown,
  input  logic [DUTY_W-1:0]     duty,
  input  logic [TIMER_BITS-1:0] timer_period,
  input  logic                  comparator_enabled,
  input  logic                  timer_clear,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic                  shutdown;
    logic [DUTY_W-1:0]     duty;
    logic [TIMER_BITS-1:0] timer_period;
    logic                  comparator_enabled;
    logic                  timer_clear;
  } ctl_result_t;

  cfg_t        regs;
  ctl_state_t  ctl;
  ctl_result_t awaited_results[$];
  ctl_result_t oldest;
  int          errors = 0;

  // Duty from the open circuit voltage in Q16: negative values clamp to zero.
  function automatic logic [DUTY_W-1:0] duty_for_voc(logic [ADC_BITS-1:0] voc);
    logic [63:0] gain_term;
    logic [63:0] offset_term;
    logic [63:0] excess;
    gain_term   = 64'(voc) * 64'(GAIN_Q16);
    offset_term = 64'(OFFSET_Q16) << ADC_BITS;
    if (gain_term < offset_term) return '0;
    excess = (gain_term - offset_term) >> DUTY_SHIFT;
    if (excess > 64'(DUTY_MAX)) return DUTY_MAX;
    return excess[DUTY_W-1:0];
  endfunction

  // Applies one event to the predicted controller state and returns the result it shows.
  function automatic ctl_result_t advance_controller(logic ev, logic [TIMER_BITS-1:0] count,
                                                      logic [ADC_BITS-1:0] vbat,
                                                      logic [ADC_BITS-1:0] voc);
    ctl_result_t                      r;
    int                               next_cycle;
    logic [TIMER_BITS+STRETCH_W-1:0] stretched;
    r.timer_clear = 1'b0;
    if (ev == CMD_EDGE) begin
      // Edges are ignored entirely while the comparator is off.
      if (ctl.edge_enable) begin
        if (ctl.falling_edge_select) begin
          ctl.shutdown_level      = 1'b1;
          ctl.falling_edge_select = 1'b0;
          r.timer_clear           = 1'b1;
        end else begin
          // The count is bumped before the compare, so 63 plus one is always past the limit.
          next_cycle              = int'(ctl.cycle_count) + 1;
          ctl.falling_edge_select = 1'b1;
          if (next_cycle > int'(regs.cycle_limit)) begin
            ctl.cycle_count = '0;
            ctl.edge_enable = 1'b0;
            stretched       = regs.stretch_factor * count;
            ctl.period_reg  = stretched[TIMER_BITS-1:0];
          end else begin
            ctl.cycle_count    = CYCLE_W'(next_cycle);
            ctl.shutdown_level = 1'b0;
          end
        end
      end
    end else begin
      ctl.period_reg = regs.base_period;
      if (!ctl.shutdown_level) begin
        ctl.falling_edge_select = 1'b0;
        ctl.shutdown_level      = 1'b1;
      end else if (vbat >= regs.vbat_limit) begin
        // Full battery: only the comparator is switched off, besides the period reload above.
        ctl.edge_enable = 1'b0;
      end else begin
        ctl.duty_reg            = duty_for_voc(voc);
        ctl.shutdown_level      = 1'b0;
        ctl.falling_edge_select = 1'b1;
        ctl.edge_enable         = 1'b1;
      end
    end
    r.shutdown           = ctl.shutdown_level;
    r.duty               = ctl.duty_reg;
    r.timer_period       = ctl.period_reg;
    r.comparator_enabled = ctl.edge_enable;
    return r;
  endfunction

  task automatic note_failure(string what);
    errors++;
    if (errors <= 10) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v)
      note_failure($sformatf("%s expected %0d, got %0d", field, want_v, got_v));
  endtask

  // Results are checked before the event of the same edge is predicted: a result always
  // belongs to an event accepted at an earlier edge.
  always @(posedge clk) begin
    if (rst) begin
      regs.vbat_limit     = VBAT_LIMIT_RST;
      regs.cycle_limit    = CYCLE_LIMIT_RST;
      regs.base_period    = BASE_PERIOD_RST;
      regs.stretch_factor = STRETCH_FACTOR_RST;
      ctl = '{shutdown_level: 1'b0, falling_edge_select: 1'b0, edge_enable: 1'b1,
              cycle_count: CYCLE_W'(1), period_reg: BASE_PERIOD_RST, duty_reg: '0};
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_failure("result beat with no event waiting for it");
        end else begin
          oldest = awaited_results.pop_front();
          check_field("shutdown", 16'(oldest.shutdown), 16'(shutdown));
          check_field("duty", 16'(oldest.duty), 16'(duty));
          check_field("timer_period", oldest.timer_period, timer_period);
          check_field("comparator_enabled", 16'(oldest.comparator_enabled),
                      16'(comparator_enabled));
          check_field("timer_clear", 16'(oldest.timer_clear), 16'(timer_clear));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_VBAT_LIMIT:     regs.vbat_limit     = cfg_data[ADC_BITS-1:0];
          REG_CYCLE_LIMIT:    regs.cycle_limit    = cfg_data[CYCLE_W-1:0];
          REG_BASE_PERIOD:    regs.base_period    = cfg_data[TIMER_BITS-1:0];
          REG_STRETCH_FACTOR: regs.stretch_factor = cfg_data[STRETCH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(advance_controller(cmd, timer_count, vbat_sample,
                                                     voc_sample));
    end
    mismatches  <= errors;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/tb_fractional_voc_mppt_controller.sv =====
// Stimulus, flow control and verdict for the fractional open circuit voltage charge controller.
`timescale 1ns / 1ps
module tb_fractional_voc_mppt_controller;
  import fvoc_pkg::*;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_VBAT_LIMIT;
  logic [CFG_W-1:0]      cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  cmd         = CMD_EDGE;
  logic [TIMER_BITS-1:0] timer_count = '0;
  logic [ADC_BITS-1:0]   vbat_sample = '0;
  logic [ADC_BITS-1:0]   voc_sample  = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  shutdown;
  logic [DUTY_W-1:0]     duty;
  logic [TIMER_BITS-1:0] timer_period;
  logic                  comparator_enabled;
  logic                  timer_clear;
  int                    mismatches;
  int                    outstanding;

  // Percent chance per cycle that each side holds off.
  int                    send_idle_pct = 10;
  int                    recv_idle_pct = 73;

  // Settings in force, used only to shape the stimulus.
  logic [ADC_BITS-1:0]   vbat_limit_now  = VBAT_LIMIT_RST;
  logic [CYCLE_W-1:0]    cycle_limit_now = CYCLE_LIMIT_RST;

  fractional_voc_mppt_controller dut (.*);
  fvoc_result_checker checker_inst (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Generous bound on the whole run.
  initial begin
    #10_000_000;
    $display("tb_fractional_voc_mppt_controller NOT OK");
    $finish;
  end

  // Presents one event beat, after optional idle cycles, and holds it until accepted.
  task automatic send_event(logic ev, logic [TIMER_BITS-1:0] count,
                            logic [ADC_BITS-1:0] vbat, logic [ADC_BITS-1:0] voc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= ev;
    timer_count <= count;
    vbat_sample <= vbat;
    voc_sample  <= voc;
    do @(posedge clk); while (in_stall);
  endtask

  // Leaves cfg_write high so that writes can follow back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] vbat_lim, logic [CFG_W-1:0] cycle_lim,
                              logic [CFG_W-1:0] base, logic [CFG_W-1:0] stretch);
    write_reg(REG_VBAT_LIMIT, vbat_lim);
    write_reg(REG_CYCLE_LIMIT, cycle_lim);
    write_reg(REG_BASE_PERIOD, base);
    write_reg(REG_STRETCH_FACTOR, stretch);
    cfg_write       <= 1'b0;
    vbat_limit_now  = vbat_lim[ADC_BITS-1:0];
    cycle_limit_now = cycle_lim[CYCLE_W-1:0];
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [TIMER_BITS-1:0] pick_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return TIMER_BITS'($urandom_range(65535));
    endcase
  endfunction

  // Mostly any voltage, sometimes right at the point where the unclamped duty turns negative.
  function automatic logic [ADC_BITS-1:0] pick_voc();
    if ($urandom_range(9) == 0) return ADC_BITS'($urandom_range(1424, 1420));
    return ADC_BITS'($urandom_range(4095));
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_vbat(bit full);
    if (full || vbat_limit_now == 0) return ADC_BITS'($urandom_range(4095, vbat_limit_now));
    return ADC_BITS'($urandom_range(vbat_limit_now - 1));
  endfunction

  // Mostly charge runs of random length, some long enough to reach the cycle limit, followed by timer
  // events, the rest any event with any content.
  task automatic random_events(int count);
    int issued;
    int runs;
    int k;
    issued = 0;
    while (issued < count) begin
      if ($urandom_range(9) < 7) begin
        runs = $urandom_range(2 * int'(cycle_limit_now) + 4, 1);
        for (k = 0; k < runs; k++)
          send_event(CMD_EDGE, pick_count(), ADC_BITS'($urandom_range(4095)), pick_voc());
        issued += runs;
        runs = $urandom_range(3, 1);
        for (k = 0; k < runs; k++)
          send_event(CMD_TIMER, pick_count(), pick_vbat($urandom_range(99) < 15), pick_voc());
        issued += runs;
      end else begin
        runs = $urandom_range(8, 1);
        for (k = 0; k < runs; k++)
          send_event(1'($urandom_range(1)), pick_count(), ADC_BITS'($urandom_range(4095)),
                     pick_voc());
        issued += runs;
      end
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] vbat_lim, logic [CFG_W-1:0] cycle_lim,
                           logic [CFG_W-1:0] base, logic [CFG_W-1:0] stretch, int count);
    settle();
    program_regs(vbat_lim, cycle_lim, base, stretch);
    random_events(count);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a one-cycle limit and the widest settings.
    program_regs(16'd4095, 16'd1, 16'hFFFF, 16'd15);
    send_event(CMD_EDGE, 16'hFFFF, 12'd0, 12'd0);       // stretch product truncated
    send_event(CMD_EDGE, 16'h1234, 12'd0, 12'd0);       // comparator off: ignored
    send_event(CMD_TIMER, 16'd0, 12'd0, 12'd0);         // discharge starts
    send_event(CMD_TIMER, 16'd0, 12'd4095, 12'd4095);   // full battery
    send_event(CMD_TIMER, 16'd0, 12'd0, 12'd4095);      // largest duty
    send_event(CMD_EDGE, 16'd77, 12'hFFF, 12'hFFF);     // falling edge clears the timer
    send_event(CMD_EDGE, 16'd0, 12'd0, 12'd0);
    send_event(CMD_EDGE, 16'd0, 12'd0, 12'd0);
    send_event(CMD_EDGE, 16'd0, 12'd0, 12'd0);         // stretch to a zero period
    send_event(CMD_TIMER, 16'hFFFF, 12'd4094, 12'd0);   // negative duty clamps
    send_event(CMD_EDGE, 16'd5, 12'd0, 12'd0);
    send_event(CMD_TIMER, 16'd0, 12'd4094, 12'd1422);   // just below the negative clamp threshold
    send_event(CMD_TIMER, 16'd0, 12'd0, 12'd0);
    send_event(CMD_TIMER, 16'd0, 12'd4094, 12'd1423);   // just above it
    send_event(CMD_TIMER, 16'd0, 12'd0, 12'd0);
    send_event(CMD_TIMER, 16'd0, 12'd2048, 12'd2048);

    run_phase(16'd3823, 16'd20, 16'd64000, 16'd6, 250);

    send_idle_pct = 73;
    recv_idle_pct = 10;
    run_phase(16'd4095, 16'd63, 16'd1, 16'd15, 300);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'd2000, 16'd3, 16'd1000, 16'd9, 250);
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)), 250);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_fractional_voc_mppt_controller OK");
    end else begin
      $display("tb_fractional_voc_mppt_controller NOT OK");
    end
    $finish;
  end

endmodule
